// File: rtl/dmrc_pkg.sv
// ----------------------------------------------------------------------------
// dmrc_pkg
// Shared constants, codes and types of the dual motor ramp controller.
// ----------------------------------------------------------------------------
package dmrc_pkg;

   // Speed width default (unsigned fraction, all ones stands for full duty)
   localparam int SPEED_BITS_DEF = 16;

   // Fixed field widths
   localparam int OP_W       = 2;
   localparam int MODE_W     = 2;
   localparam int RATE_W     = 16;
   localparam int TOL_W      = 16;
   localparam int TIME_W     = 24;
   localparam int STEP_SHIFT = 10;   // rates are given per 1024 us

   // Operation codes
   localparam logic [OP_W-1:0] OP_TICK   = 2'd0;
   localparam logic [OP_W-1:0] OP_TARGET = 2'd1;
   localparam logic [OP_W-1:0] OP_DIR    = 2'd2;
   localparam logic [OP_W-1:0] OP_HALT   = 2'd3;

   // Mode codes
   localparam logic [MODE_W-1:0] MODE_STOP  = 2'd0;
   localparam logic [MODE_W-1:0] MODE_RUN   = 2'd1;
   localparam logic [MODE_W-1:0] MODE_TURN  = 2'd2;
   localparam logic [MODE_W-1:0] MODE_EMERG = 2'd3;

   // CSR map
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;
   localparam int REG_IDX_W  = 2;
   localparam logic [REG_IDX_W-1:0] REG_ACCEL   = 2'd0;
   localparam logic [REG_IDX_W-1:0] REG_DECEL   = 2'd1;
   localparam logic [REG_IDX_W-1:0] REG_TOL     = 2'd2;
   localparam logic [REG_IDX_W-1:0] REG_ELAPSED = 2'd3;

   // CSR reset values
   localparam logic [RATE_W-1:0] ACCEL_RST   = 16'd1024;
   localparam logic [RATE_W-1:0] DECEL_RST   = 16'd1024;
   localparam logic [TOL_W-1:0]  TOL_RST     = 16'd655;
   localparam logic [TIME_W-1:0] ELAPSED_RST = 24'd100000;

   // Per-lane status toward the merge logic
   typedef struct packed {
      logic near;       // error magnitude below tolerance
      logic goal_low;   // goal below tolerance
      logic moving;     // speed nonzero
   } lane_flags_type;

endpackage

// File: rtl/dmrc_if.sv
// ----------------------------------------------------------------------------
// dmrc_if
// Valid/ready channels for commands and status of the ramp controller.
// ----------------------------------------------------------------------------
interface dmrc_req_if #(
   parameter int SPEED_BITS = dmrc_pkg::SPEED_BITS_DEF
);
   logic                          valid;
   logic                          ready;
   logic [dmrc_pkg::OP_W-1:0]     operation;
   logic [dmrc_pkg::TIME_W-1:0]   elapsed_us;
   logic [SPEED_BITS-1:0]         target_left;
   logic [SPEED_BITS-1:0]         target_right;
   logic                          left_dir;
   logic                          right_dir;

   modport source (output valid, operation, elapsed_us, target_left, target_right,
                   left_dir, right_dir, input ready);
   modport sink   (input valid, operation, elapsed_us, target_left, target_right,
                   left_dir, right_dir, output ready);
endinterface

interface dmrc_rsp_if #(
   parameter int SPEED_BITS = dmrc_pkg::SPEED_BITS_DEF
);
   logic                          valid;
   logic                          ready;
   logic [SPEED_BITS-1:0]         pwm_left;
   logic [SPEED_BITS-1:0]         pwm_right;
   logic                          dir_pin_left;
   logic                          dir_pin_right;
   logic [dmrc_pkg::MODE_W-1:0]   mode;

   modport source (output valid, pwm_left, pwm_right, dir_pin_left, dir_pin_right, mode,
                   input ready);
   modport sink   (input valid, pwm_left, pwm_right, dir_pin_left, dir_pin_right, mode,
                   output ready);
endinterface

// File: rtl/dmrc_step.sv
// ----------------------------------------------------------------------------
// dmrc_step
// First stage: turns elapsed time into accel and decel steps, registered.
// ----------------------------------------------------------------------------
module dmrc_step #(
   parameter int SPEED_BITS = dmrc_pkg::SPEED_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          load,
   input  logic [dmrc_pkg::TIME_W-1:0]   elapsed_us,
   input  logic [dmrc_pkg::RATE_W-1:0]   max_accel,
   input  logic [dmrc_pkg::RATE_W-1:0]   max_decel,
   input  logic [dmrc_pkg::TIME_W-1:0]   max_elapsed_us,
   output logic [SPEED_BITS-1:0]         acc_step,
   output logic [SPEED_BITS-1:0]         dec_step
);
   import dmrc_pkg::*;

   localparam int PROD_W = RATE_W + TIME_W;
   localparam int STEP_W = PROD_W - STEP_SHIFT;
   localparam int WIDE_W = (STEP_W > SPEED_BITS) ? STEP_W : SPEED_BITS;
   localparam logic [WIDE_W-1:0] SPEED_MAX = WIDE_W'({SPEED_BITS{1'b1}});

   logic [TIME_W-1:0]     dt;
   logic [PROD_W-1:0]     acc_prod, dec_prod;
   logic [WIDE_W-1:0]     acc_wide, dec_wide;
   logic [SPEED_BITS-1:0] acc_ff, acc_in, dec_ff, dec_in;

   // long pauses apply no ramp change
   assign dt       = (elapsed_us > max_elapsed_us) ? '0 : elapsed_us;
   assign acc_prod = PROD_W'(max_accel) * PROD_W'(dt);
   assign dec_prod = PROD_W'(max_decel) * PROD_W'(dt);
   assign acc_wide = WIDE_W'(acc_prod[PROD_W-1:STEP_SHIFT]);
   assign dec_wide = WIDE_W'(dec_prod[PROD_W-1:STEP_SHIFT]);

   // a step beyond full scale behaves like full scale downstream
   assign acc_in = (acc_wide > SPEED_MAX) ? SPEED_MAX[SPEED_BITS-1:0]
                                          : acc_wide[SPEED_BITS-1:0];
   assign dec_in = (dec_wide > SPEED_MAX) ? SPEED_MAX[SPEED_BITS-1:0]
                                          : dec_wide[SPEED_BITS-1:0];

   always_ff @(posedge clock) begin
      if (load) begin
         acc_ff <= acc_in;
         dec_ff <= dec_in;
      end
   end

   assign acc_step = acc_ff;
   assign dec_step = dec_ff;

endmodule

// File: rtl/dmrc_lane.sv
// ----------------------------------------------------------------------------
// dmrc_lane
// One motor lane: ramp toward goal, slow-down step and tolerance flags.
// ----------------------------------------------------------------------------
module dmrc_lane #(
   parameter int SPEED_BITS = dmrc_pkg::SPEED_BITS_DEF
) (
   input  logic [SPEED_BITS-1:0]        speed,
   input  logic [SPEED_BITS-1:0]        goal,
   input  logic [SPEED_BITS-1:0]        acc_step,
   input  logic [SPEED_BITS-1:0]        dec_step,
   input  logic [dmrc_pkg::TOL_W-1:0]   tolerance,
   output logic [SPEED_BITS-1:0]        speed_ramp,
   output logic [SPEED_BITS-1:0]        speed_slow,
   output dmrc_pkg::lane_flags_type     flags
);
   import dmrc_pkg::*;

   localparam int CMP_W = (SPEED_BITS > TOL_W) ? SPEED_BITS : TOL_W;

   logic                  up;
   logic [SPEED_BITS-1:0] mag, step;

   assign up   = goal > speed;
   assign mag  = up ? (goal - speed) : (speed - goal);
   assign step = up ? acc_step : dec_step;

   // a step that reaches the goal lands on it exactly
   always_comb begin
      if (mag == '0) begin
         speed_ramp = speed;
      end else if (step >= mag) begin
         speed_ramp = goal;
      end else if (up) begin
         speed_ramp = speed + step;
      end else begin
         speed_ramp = speed - step;
      end
   end

   assign speed_slow = (speed > dec_step) ? (speed - dec_step) : '0;

   assign flags.near     = CMP_W'(mag)  < CMP_W'(tolerance);
   assign flags.goal_low = CMP_W'(goal) < CMP_W'(tolerance);
   assign flags.moving   = speed != '0;

endmodule

// File: rtl/dual_motor_ramp_controller.sv
// ----------------------------------------------------------------------------
// dual_motor_ramp_controller
// Two-motor speed ramp controller: stopped, running, direction change and
// emergency modes, slew-limited PWM speeds, APB-style register port.
// ----------------------------------------------------------------------------
//  channel   direction  handshake                     carries
//  req_chan  in         valid/ready                   operation, time, targets, dirs
//  rsp_chan  out        valid/ready                   pwm, direction pins, mode
//  csr_*     in/out     psel/penable, pready tied 1   accel, decel, tolerance, max time
//
//  Two stages: the step stage multiplies both rates by the elapsed time, the
//  lane/merge stage updates the motor state and fills the output register.
//  One transfer per cycle sustained while rsp_chan is not stalled; a request is
//  registered in the step stage, then its result in the output register.
//  req_chan.ready drops only when both stages are full and rsp_chan is stalled.
//  Reset (synchronous) clears modes, speeds, goals, directions and valid flags and loads CSR reset values.
// ----------------------------------------------------------------------------
module dual_motor_ramp_controller #(
   parameter int SPEED_BITS = dmrc_pkg::SPEED_BITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   dmrc_req_if.sink                           req_chan,
   dmrc_rsp_if.source                         rsp_chan,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [dmrc_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [dmrc_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [dmrc_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                               csr_pready
);
   import dmrc_pkg::*;

   // ---------------------------------------------------------------- CSRs
   logic                 csr_wr;
   logic [REG_IDX_W-1:0] csr_idx;
   logic [RATE_W-1:0]    accel_ff, accel_in, decel_ff, decel_in;
   logic [TOL_W-1:0]     tol_ff, tol_in;
   logic [TIME_W-1:0]    max_el_ff, max_el_in;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_idx    = csr_paddr[CSR_ADDR_W-1:2];

   always_comb begin
      accel_in  = accel_ff;
      decel_in  = decel_ff;
      tol_in    = tol_ff;
      max_el_in = max_el_ff;
      if (csr_wr) begin
         unique case (csr_idx)
            REG_ACCEL:   accel_in  = csr_pwdata[RATE_W-1:0];
            REG_DECEL:   decel_in  = csr_pwdata[RATE_W-1:0];
            REG_TOL:     tol_in    = csr_pwdata[TOL_W-1:0];
            REG_ELAPSED: max_el_in = csr_pwdata[TIME_W-1:0];
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         REG_ACCEL:   csr_prdata = CSR_DATA_W'(accel_ff);
         REG_DECEL:   csr_prdata = CSR_DATA_W'(decel_ff);
         REG_TOL:     csr_prdata = CSR_DATA_W'(tol_ff);
         REG_ELAPSED: csr_prdata = CSR_DATA_W'(max_el_ff);
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         accel_ff  <= ACCEL_RST;
         decel_ff  <= DECEL_RST;
         tol_ff    <= TOL_RST;
         max_el_ff <= ELAPSED_RST;
      end else begin
         accel_ff  <= accel_in;
         decel_ff  <= decel_in;
         tol_ff    <= tol_in;
         max_el_ff <= max_el_in;
      end
   end

   // ---------------------------------------------------------------- flow
   logic rsp_valid_ff, rsp_valid_in;
   logic s1_valid_ff, s1_valid_in;
   logic out_free, s1_free, s1_move, req_take;

   // output register takes a new result when empty or being drained
   assign out_free = !rsp_valid_ff || rsp_chan.ready;
   assign s1_move  = s1_valid_ff && out_free;
   assign s1_free  = !s1_valid_ff || out_free;
   assign req_chan.ready = s1_free;
   assign req_take = req_chan.valid && s1_free;

   assign s1_valid_in  = req_take ? 1'b1 : (s1_move ? 1'b0 : s1_valid_ff);
   assign rsp_valid_in = s1_move ? 1'b1 : (rsp_chan.ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // ---------------------------------------------------------------- stage 1
   logic [OP_W-1:0]       s1_op_ff;
   logic [SPEED_BITS-1:0] s1_tgt_l_ff, s1_tgt_r_ff;
   logic [1:0]            s1_dirs_ff;   // bit 0 left, bit 1 right
   logic [SPEED_BITS-1:0] acc_step, dec_step;

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_op_ff    <= req_chan.operation;
         s1_tgt_l_ff <= req_chan.target_left;
         s1_tgt_r_ff <= req_chan.target_right;
         s1_dirs_ff  <= {req_chan.right_dir, req_chan.left_dir};
      end
   end

   dmrc_step #(.SPEED_BITS(SPEED_BITS)) u_step (
      .clock          (clock),
      .load           (req_take),
      .elapsed_us     (req_chan.elapsed_us),
      .max_accel      (accel_ff),
      .max_decel      (decel_ff),
      .max_elapsed_us (max_el_ff),
      .acc_step       (acc_step),
      .dec_step       (dec_step)
   );

   // ---------------------------------------------------------------- state
   logic [MODE_W-1:0]     mode_ff, mode_in, entered_ff, entered_in;
   logic [SPEED_BITS-1:0] spd_l_ff, spd_l_in, spd_r_ff, spd_r_in;
   logic [SPEED_BITS-1:0] goal_l_ff, goal_l_in, goal_r_ff, goal_r_in;
   logic [1:0]            wanted_ff, wanted_in, latched_ff, latched_in;

   // Deferred entry action of the current mode, applied ahead of the handler
   // on a tick. Stop and emergency clear speeds, turn and emergency clear goals.
   logic                  pending, clr_spd, clr_goal;
   logic [SPEED_BITS-1:0] e_spd_l, e_spd_r, e_goal_l, e_goal_r;

   assign pending  = mode_ff != entered_ff;
   assign clr_spd  = pending && ((mode_ff == MODE_STOP) || (mode_ff == MODE_EMERG));
   assign clr_goal = pending && ((mode_ff == MODE_TURN) || (mode_ff == MODE_EMERG));
   assign e_spd_l  = clr_spd  ? '0 : spd_l_ff;
   assign e_spd_r  = clr_spd  ? '0 : spd_r_ff;
   assign e_goal_l = clr_goal ? '0 : goal_l_ff;
   assign e_goal_r = clr_goal ? '0 : goal_r_ff;

   // ---------------------------------------------------------------- lanes
   logic [SPEED_BITS-1:0] ramp_l, ramp_r, slow_l, slow_r;
   lane_flags_type        flags_l, flags_r;

   dmrc_lane #(.SPEED_BITS(SPEED_BITS)) u_lane_left (
      .speed      (e_spd_l),
      .goal       (e_goal_l),
      .acc_step   (acc_step),
      .dec_step   (dec_step),
      .tolerance  (tol_ff),
      .speed_ramp (ramp_l),
      .speed_slow (slow_l),
      .flags      (flags_l)
   );

   dmrc_lane #(.SPEED_BITS(SPEED_BITS)) u_lane_right (
      .speed      (e_spd_r),
      .goal       (e_goal_r),
      .acc_step   (acc_step),
      .dec_step   (dec_step),
      .tolerance  (tol_ff),
      .speed_ramp (ramp_r),
      .speed_slow (slow_r),
      .flags      (flags_r)
   );

   // ---------------------------------------------------------------- merge
   always_comb begin
      mode_in    = mode_ff;
      entered_in = entered_ff;
      spd_l_in   = spd_l_ff;
      spd_r_in   = spd_r_ff;
      goal_l_in  = goal_l_ff;
      goal_r_in  = goal_r_ff;
      wanted_in  = wanted_ff;
      latched_in = latched_ff;
      unique case (s1_op_ff)
         OP_TICK: begin
            entered_in = mode_ff;
            spd_l_in   = e_spd_l;
            spd_r_in   = e_spd_r;
            goal_l_in  = e_goal_l;
            goal_r_in  = e_goal_r;
            unique case (mode_ff)
               MODE_RUN: begin
                  spd_l_in = ramp_l;
                  spd_r_in = ramp_r;
                  // both lanes settled near a goal below tolerance
                  if (flags_l.near && flags_r.near && flags_l.goal_low && flags_r.goal_low)
                  begin
                     mode_in = MODE_STOP;
                  end
               end
               MODE_STOP: begin
                  if ((e_goal_l != '0) || (e_goal_r != '0)) begin
                     mode_in = MODE_RUN;
                  end
               end
               MODE_TURN: begin
                  spd_l_in = slow_l;
                  spd_r_in = slow_r;
                  // both motors were already still: take the new directions
                  if (!flags_l.moving && !flags_r.moving) begin
                     latched_in = wanted_ff;
                     mode_in    = MODE_STOP;
                  end
               end
               MODE_EMERG: begin
               end
            endcase
         end
         OP_TARGET: begin
            // targets are dropped while turning or in emergency
            if ((mode_ff != MODE_EMERG) && (mode_ff != MODE_TURN)) begin
               goal_l_in = s1_tgt_l_ff;
               goal_r_in = s1_tgt_r_ff;
            end
         end
         OP_DIR: begin
            wanted_in = s1_dirs_ff;
            mode_in   = MODE_TURN;
            goal_l_in = '0;
            goal_r_in = '0;
         end
         OP_HALT: begin
            mode_in = MODE_EMERG;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= MODE_STOP;
         entered_ff <= MODE_STOP;
         spd_l_ff   <= '0;
         spd_r_ff   <= '0;
         goal_l_ff  <= '0;
         goal_r_ff  <= '0;
         wanted_ff  <= '0;
         latched_ff <= '0;
      end else if (s1_move) begin
         mode_ff    <= mode_in;
         entered_ff <= entered_in;
         spd_l_ff   <= spd_l_in;
         spd_r_ff   <= spd_r_in;
         goal_l_ff  <= goal_l_in;
         goal_r_ff  <= goal_r_in;
         wanted_ff  <= wanted_in;
         latched_ff <= latched_in;
      end
   end

   // ---------------------------------------------------------------- output
   logic [SPEED_BITS-1:0] pwm_l_ff, pwm_r_ff;
   logic                  pin_l_ff, pin_r_ff;
   logic [MODE_W-1:0]     mode_out_ff;

   always_ff @(posedge clock) begin
      if (s1_move) begin
         pwm_l_ff    <= spd_l_in;
         pwm_r_ff    <= spd_r_in;
         pin_l_ff    <= ~latched_in[0];   // left pin is wired inverted
         pin_r_ff    <= latched_in[1];
         mode_out_ff <= mode_in;
      end
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.pwm_left      = pwm_l_ff;
   assign rsp_chan.pwm_right     = pwm_r_ff;
   assign rsp_chan.dir_pin_left  = pin_l_ff;
   assign rsp_chan.dir_pin_right = pin_r_ff;
   assign rsp_chan.mode          = mode_out_ff;

endmodule

// File: rtl/dmrc_checker.sv
// ----------------------------------------------------------------------------
// dmrc_checker
// Port-level checks of the ramp controller, bound to the top level.
// ----------------------------------------------------------------------------
module dmrc_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic                          rsp_dir_pin_left,
   input logic                          rsp_dir_pin_right,
   input logic [dmrc_pkg::MODE_W-1:0]   rsp_mode
);
   import dmrc_pkg::*;

   logic       req_acc, rsp_acc;
   logic [1:0] cnt_ff, cnt_in;
   logic [1:0] pins_ff, pins_in;

   assign req_acc = req_valid && req_ready;
   assign rsp_acc = rsp_valid && rsp_ready;
   assign cnt_in  = cnt_ff + {1'b0, req_acc} - {1'b0, rsp_acc};
   assign pins_in = rsp_acc ? {rsp_dir_pin_right, rsp_dir_pin_left} : pins_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         pins_ff <= 2'b01;   // pins after reset: left high, right low
      end else begin
         cnt_ff  <= cnt_in;
         pins_ff <= pins_in;
      end
   end

   // stalled result stays valid and keeps its mode
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_mode))
      else $error("result changed while stalled");

   // no more than two transfers in flight
   a_depth: assert property (@(posedge clock) disable iff (reset)
      cnt_ff != 2'd3)
      else $error("too many transfers in flight");

   // every result belongs to an accepted request
   a_no_extra: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> cnt_ff != 2'd0)
      else $error("result without request");

   // direction pins only switch when a direction change completes
   a_dir_switch: assert property (@(posedge clock) disable iff (reset)
      rsp_acc && ({rsp_dir_pin_right, rsp_dir_pin_left} != pins_ff)
      |-> rsp_mode == MODE_STOP)
      else $error("direction pins changed outside a completed turn");

endmodule

bind dual_motor_ramp_controller dmrc_checker u_dmrc_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_chan.valid),
   .req_ready         (req_chan.ready),
   .rsp_valid         (rsp_chan.valid),
   .rsp_ready         (rsp_chan.ready),
   .rsp_dir_pin_left  (rsp_chan.dir_pin_left),
   .rsp_dir_pin_right (rsp_chan.dir_pin_right),
   .rsp_mode          (rsp_chan.mode)
);
